[sv/mrcs_pkg.sv]
// ----------------------------------------------------------------------------
// mrcs_pkg: shared types and codes for the marked record compaction store
// Record, request and response layouts plus function and status codes.
// ----------------------------------------------------------------------------
package mrcs_pkg;

   localparam int ID_W      = 32;
   localparam int REAL_ID_W = 31;
   localparam int KIND_W    = 8;
   localparam int PAYLOAD_W = 32;
   localparam int SLOT_W    = 8;
   localparam int FUNC_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 9;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_MARK    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPACT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

   // one stored record, top id bit is the mark
   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [KIND_W-1:0]    kind;
      logic [PAYLOAD_W-1:0] payload;
   } rec_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [KIND_W-1:0]    kind_in;
      logic [PAYLOAD_W-1:0] payload_in;
      logic [SLOT_W-1:0]    slot;
      logic [ID_W-1:0]      key_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SLOT_W-1:0]    found_index;
      logic [REAL_ID_W-1:0] real_id;
      logic [KIND_W-1:0]    kind_out;
      logic [PAYLOAD_W-1:0] payload_out;
      logic [COUNT_W-1:0]   live_count;
      logic [COUNT_W-1:0]   removed_count;
   } rsp_type;

endpackage

[sv/mrcs_ram.sv]
// ----------------------------------------------------------------------------
// mrcs_ram: record memory
// One write port and one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module mrcs_ram
   import mrcs_pkg::*;
#(
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  rec_type           wdata,
   input  logic [ADDR_W-1:0] raddr,
   output rec_type           rdata
);

   rec_type mem [DEPTH];
   rec_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/marked_record_compaction_store_top.sv]
// ----------------------------------------------------------------------------
// marked_record_compaction_store_top: particle record store with compaction
// Append, mark, compact, read and find over a record memory with one read
// and one write port, run by a small sequencer around one pointer compare unit.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one response
// appears on rsp_item for a single cycle with rsp_valid high and must be
// taken then, since the block has no way to hold it. Append, full-store
// append, out-of-range mark or read and unused codes answer in the cycle
// after start. Mark and read answer from the mark-write or read-response
// state after one memory read. Find reads one record per cycle and stops
// at a match or after the last live record. Compact moves a low pointer
// up to a marked record and a high pointer down to an unmarked one, swaps
// the two and, once the pointers meet, clears the mark on each tail record.
// These sequences come from the memory's single read port and its
// registered read data. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module marked_record_compaction_store_top
   import mrcs_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   // sequencer states
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] ST_MARK_WR  = 4'd1;
   localparam logic [ST_W-1:0] ST_READ_RSP = 4'd2;
   localparam logic [ST_W-1:0] ST_FIND     = 4'd3;
   localparam logic [ST_W-1:0] ST_LO_SCAN  = 4'd4;
   localparam logic [ST_W-1:0] ST_LO_CHK   = 4'd5;
   localparam logic [ST_W-1:0] ST_HI_SCAN  = 4'd6;
   localparam logic [ST_W-1:0] ST_HI_CHK   = 4'd7;
   localparam logic [ST_W-1:0] ST_SWAP_WR  = 4'd8;
   localparam logic [ST_W-1:0] ST_CLR      = 4'd9;

   logic [ST_W-1:0]      state_ff, state_in;
   req_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [REAL_ID_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic                 chk_ff, chk_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   rec_type              lo_rec_ff, lo_rec_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   rec_type              mem_wdata;
   logic [IDX_W-1:0]     mem_raddr;
   rec_type              mem_rdata;

   logic                 accept;
   logic                 slot_ok;
   logic                 ptr_meet;
   logic [REAL_ID_W-1:0] next_id;

   mrcs_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // shared compare and small helpers
   assign accept   = start && (state_ff == ST_IDLE);
   assign slot_ok  = CMP_W'(req_item.slot) < CMP_W'(used_ff);
   assign ptr_meet = lo_ff >= hi_ff;
   assign next_id  = last_ff + 1'b1;

   // sequencer
   always_comb begin
      rec_type wr_rec;
      rsp_type rsp_base;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      used_in      = used_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      lo_rec_in    = lo_rec_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = mem_rdata;
      mem_raddr    = '0;

      wr_rec   = mem_rdata;
      rsp_base = '0;
      rsp_base.live_count = COUNT_W'(used_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_item;
               case (req_item.func)
                  FUNC_APPEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = rsp_base;
                     if (used_ff == FULL_CNT) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        mem_we            = 1'b1;
                        mem_waddr         = IDX_W'(used_ff);
                        mem_wdata.id      = {1'b0, next_id};
                        mem_wdata.kind    = req_item.kind_in;
                        mem_wdata.payload = req_item.payload_in;
                        last_in           = next_id;
                        used_in           = used_ff + 1'b1;
                        rsp_in.found_index = SLOT_W'(used_ff);
                        rsp_in.real_id     = next_id;
                        rsp_in.live_count  = COUNT_W'(used_ff + 1'b1);
                     end
                  end
                  FUNC_MARK: begin
                     if (slot_ok) begin
                        mem_raddr = IDX_W'(req_item.slot);
                        state_in  = ST_MARK_WR;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in        = rsp_base;
                        rsp_in.status = STATUS_RANGE;
                     end
                  end
                  FUNC_READ: begin
                     if (slot_ok) begin
                        mem_raddr = IDX_W'(req_item.slot);
                        state_in  = ST_READ_RSP;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in        = rsp_base;
                        rsp_in.status = STATUS_RANGE;
                     end
                  end
                  FUNC_COMPACT: begin
                     lo_in    = '0;
                     hi_in    = used_ff;
                     state_in = ST_LO_SCAN;
                  end
                  FUNC_FIND: begin
                     lo_in    = '0;
                     chk_in   = 1'b0;
                     state_in = ST_FIND;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = rsp_base;
                  end
               endcase
            end
         end

         // set the mark on the record just read
         ST_MARK_WR: begin
            wr_rec.id[ID_W-1] = 1'b1;
            mem_we       = 1'b1;
            mem_waddr    = IDX_W'(cmd_ff.slot);
            mem_wdata    = wr_rec;
            rsp_valid_in = 1'b1;
            rsp_in       = rsp_base;
            state_in     = ST_IDLE;
         end

         ST_READ_RSP: begin
            rsp_valid_in       = 1'b1;
            rsp_in             = rsp_base;
            rsp_in.real_id     = mem_rdata.id[REAL_ID_W-1:0];
            rsp_in.kind_out    = mem_rdata.kind;
            rsp_in.payload_out = mem_rdata.payload;
            state_in           = ST_IDLE;
         end

         // one read per cycle, compare the previous read
         ST_FIND: begin
            if (chk_ff && (mem_rdata.id == cmd_ff.key_id)) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = rsp_base;
               rsp_in.found_index = SLOT_W'(chk_idx_ff);
               chk_in             = 1'b0;
               state_in           = ST_IDLE;
            end else if (lo_ff < used_ff) begin
               mem_raddr  = IDX_W'(lo_ff);
               chk_in     = 1'b1;
               chk_idx_in = IDX_W'(lo_ff);
               lo_in      = lo_ff + 1'b1;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_in        = rsp_base;
               rsp_in.status = STATUS_NOT_FOUND;
               chk_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         // low pointer looks for a marked record
         ST_LO_SCAN: begin
            if (ptr_meet) begin
               hi_in    = lo_ff;
               chk_in   = 1'b0;
               state_in = ST_CLR;
            end else begin
               mem_raddr = IDX_W'(lo_ff);
               state_in  = ST_LO_CHK;
            end
         end

         ST_LO_CHK: begin
            lo_rec_in = mem_rdata;
            if (mem_rdata.id[ID_W-1]) begin
               hi_in    = hi_ff - 1'b1;
               state_in = ST_HI_SCAN;
            end else begin
               lo_in    = lo_ff + 1'b1;
               state_in = ST_LO_SCAN;
            end
         end

         // high pointer looks for an unmarked record
         ST_HI_SCAN: begin
            if (ptr_meet) begin
               hi_in    = lo_ff;
               chk_in   = 1'b0;
               state_in = ST_CLR;
            end else begin
               mem_raddr = IDX_W'(hi_ff);
               state_in  = ST_HI_CHK;
            end
         end

         ST_HI_CHK: begin
            if (!mem_rdata.id[ID_W-1]) begin
               mem_we    = 1'b1;
               mem_waddr = IDX_W'(lo_ff);
               mem_wdata = mem_rdata;
               state_in  = ST_SWAP_WR;
            end else begin
               hi_in    = hi_ff - 1'b1;
               state_in = ST_HI_SCAN;
            end
         end

         // second half of the swap
         ST_SWAP_WR: begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(hi_ff);
            mem_wdata = lo_rec_ff;
            lo_in     = lo_ff + 1'b1;
            state_in  = ST_LO_SCAN;
         end

         // clear marks on the tail, read one ahead of the write
         ST_CLR: begin
            if (chk_ff) begin
               wr_rec.id[ID_W-1] = 1'b0;
               mem_we    = 1'b1;
               mem_waddr = chk_idx_ff;
               mem_wdata = wr_rec;
            end
            if (hi_ff < used_ff) begin
               mem_raddr  = IDX_W'(hi_ff);
               chk_in     = 1'b1;
               chk_idx_in = IDX_W'(hi_ff);
               hi_in      = hi_ff + 1'b1;
            end else begin
               chk_in               = 1'b0;
               used_in              = lo_ff;
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.live_count    = COUNT_W'(lo_ff);
               rsp_in.removed_count = COUNT_W'(used_ff - lo_ff);
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         last_ff      <= REAL_ID_W'(1);
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         last_ff      <= last_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      chk_idx_ff <= chk_idx_in;
      lo_rec_ff  <= lo_rec_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // live count never passes the capacity
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FULL_CNT)
      else $error("live count above capacity");

   // partition pointers never cross
   a_ptr_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LO_SCAN || state_ff == ST_LO_CHK || state_ff == ST_HI_SCAN ||
       state_ff == ST_HI_CHK || state_ff == ST_SWAP_WR || state_ff == ST_CLR)
      |-> lo_ff <= hi_ff)
      else $error("compaction pointers crossed");

   // leaving a multi-cycle operation always gives a response
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("operation ended without a response");

   // a response follows an accepted item or ongoing work
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start) && !$past(busy)) || $past(busy))
      else $error("response without an item");

   // only the mark clear pass reports removed records
   a_removed_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.removed_count != '0) |-> $past(state_ff == ST_CLR))
      else $error("removed count outside compaction");

endmodule
